FILE: rtl/core/quadratic_root_solver_defines.svh
// ----------------------------------------------------------------------------
// quadratic root solver: assertion macros
// shared helpers for the concurrent checks of the solver
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication on clk, quiet during reset
`define QRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrs check failed");

// next-cycle implication on clk, quiet during reset
`define QRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrs check failed");

`endif

FILE: rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants and types of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int OUT_WIDTH      = 34;
	localparam int SQRT_FRAC      = 16;
	localparam int B_SHIFT        = 8;
	localparam int N_SHIFT        = 7;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_NEG   = 2'd1;
	localparam status_t STATUS_AZERO = 2'd2;

endpackage

FILE: rtl/core/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// two-stage front end: coefficient products, then discriminant and status
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
	parameter int W = COEF_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	input  logic [W-1:0]      c,
	output logic              out_valid,
	output logic [2*W+17:0]   x,
	output status_t           status,
	output logic [W-1:0]      a_out,
	output logic [W-1:0]      b_out
);

	logic [W-1:0]   amag, bmag, cmag;
	logic           vld_s1, ac_pos_s1, a_zero_s1;
	logic [W-1:0]   a_s1, b_s1;
	logic [2*W-1:0] b2_s1, p_s1;
	logic [2*W+1:0] p4, b2x, dsub, dadd;
	logic           neg;
	logic           vld_s2;
	logic [2*W+17:0] x_s2;
	status_t        status_s2;
	logic [W-1:0]   a_s2, b_s2;

	assign amag = a[W-1] ? -a : a;
	assign bmag = b[W-1] ? -b : b;
	assign cmag = c[W-1] ? -c : c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= a;
			b_s1      <= b;
			b2_s1     <= (2*W)'(bmag) * (2*W)'(bmag);
			p_s1      <= (2*W)'(amag) * (2*W)'(cmag);
			a_zero_s1 <= (a == '0);
			ac_pos_s1 <= (a != '0) && (c != '0) && (a[W-1] == c[W-1]);
		end
	end

	// no real roots when a and c share a sign and 4ac exceeds b*b
	assign p4   = {p_s1, 2'b00};
	assign b2x  = {2'b00, b2_s1};
	assign dsub = b2x - p4;
	assign dadd = b2x + p4;
	assign neg  = ac_pos_s1 && (b2x < p4);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= {1'b0, (ac_pos_s1 ? dsub[2*W:0] : dadd[2*W:0]), {SQRT_FRAC{1'b0}}};
			if (a_zero_s1)
				status_s2 <= STATUS_AZERO;
			else if (neg)
				status_s2 <= STATUS_NEG;
			else
				status_s2 <= STATUS_OK;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	assign out_valid = vld_s2;
	assign x         = x_s2;
	assign status    = status_s2;
	assign a_out     = a_s2;
	assign b_out     = b_s2;

endmodule

FILE: rtl/core/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined restoring integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; #(
	parameter int RW = COEF_WIDTH_DEF + 9,
	parameter int SW = 2 * COEF_WIDTH_DEF + 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] x,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	localparam int XW = 2 * RW;

	logic            vld_s  [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [XW-1:0]   x_s    [RW];
	logic [SW-1:0]   side_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic            v_p;
		logic [RW+1:0]   rem_p;
		logic [RW-1:0]   root_p;
		logic [XW-1:0]   x_p;
		logic [SW-1:0]   sd_p;
		logic [RW+3:0]   rem_sh, trial, diff;
		logic            take;

		if (i == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = x;
			assign sd_p   = side_in;
		end else begin : g_next
			assign v_p    = vld_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign x_p    = x_s[i-1];
			assign sd_p   = side_s[i-1];
		end

		// bring down two radicand bits, try (root << 2) | 1
		always_comb begin
			rem_sh = {rem_p, x_p[XW-1 -: 2]};
			trial  = {2'b00, root_p, 2'b01};
			diff   = rem_sh - trial;
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else if (en)
				vld_s[i] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? diff[RW+1:0] : rem_sh[RW+1:0];
				root_s[i] <= {root_p[RW-2:0], take};
				x_s[i]    <= {x_p[XW-3:0], 2'b00};
				side_s[i] <= sd_p;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

FILE: rtl/core/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// twin pipelined restoring dividers sharing one divisor, one quotient bit
// per stage
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
	parameter int NW = COEF_WIDTH_DEF + 18,
	parameter int DW = COEF_WIDTH_DEF,
	parameter int SW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num_m,
	input  logic [NW-1:0] num_p,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo_m,
	output logic [NW-1:0] quo_p,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [NW];
	logic [DW-1:0] remm_s [NW];
	logic [DW-1:0] remp_s [NW];
	logic [NW-1:0] nm_s   [NW];
	logic [NW-1:0] np_s   [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic          v_p;
		logic [DW-1:0] rm_p, rp_p, d_p;
		logic [NW-1:0] nm_p, np_p;
		logic [SW-1:0] sd_p;
		logic [DW:0]   shm, shp, dx, difm, difp;
		logic          tkm, tkp;

		if (i == 0) begin : g_first
			assign v_p  = in_valid;
			assign rm_p = '0;
			assign rp_p = '0;
			assign nm_p = num_m;
			assign np_p = num_p;
			assign d_p  = den;
			assign sd_p = side_in;
		end else begin : g_next
			assign v_p  = vld_s[i-1];
			assign rm_p = remm_s[i-1];
			assign rp_p = remp_s[i-1];
			assign nm_p = nm_s[i-1];
			assign np_p = np_s[i-1];
			assign d_p  = den_s[i-1];
			assign sd_p = side_s[i-1];
		end

		// quotient bits shift in where the dividend bits leave
		always_comb begin
			dx   = {1'b0, d_p};
			shm  = {rm_p, nm_p[NW-1]};
			shp  = {rp_p, np_p[NW-1]};
			difm = shm - dx;
			difp = shp - dx;
			tkm  = (shm >= dx);
			tkp  = (shp >= dx);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else if (en)
				vld_s[i] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remm_s[i] <= tkm ? difm[DW-1:0] : shm[DW-1:0];
				remp_s[i] <= tkp ? difp[DW-1:0] : shp[DW-1:0];
				nm_s[i]   <= {nm_p[NW-2:0], tkm};
				np_s[i]   <= {np_p[NW-2:0], tkp};
				den_s[i]  <= d_p;
				side_s[i] <= sd_p;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo_m     = nm_s[NW-1];
	assign quo_p     = np_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

FILE: rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c from fixed-point coefficients
// ----------------------------------------------------------------------------
// Takes one request (a, b, c) every cycle while in_ready is high and
// returns both roots in Q17.16, truncated toward zero and saturated,
// with a status. The path runs through the front-end registers for
// products and then discriminant, COEF_WIDTH+9 square root stages, a
// numerator set-up register, COEF_WIDTH+18 divider stages and the output register.
// The whole pipeline advances together, so a held result stalls every stage
// and nothing is dropped.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver import qrs_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COEF_WIDTH-1:0] coef_a,
	input  logic [COEF_WIDTH-1:0] coef_b,
	input  logic [COEF_WIDTH-1:0] coef_c,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_WIDTH-1:0]  root_minus,
	output logic [OUT_WIDTH-1:0]  root_plus,
	output status_t               status
);

	localparam int W   = COEF_WIDTH;
	localparam int RW  = W + 9;
	localparam int NW  = W + 18;
	localparam int SW1 = 2 * W + 2;
	localparam int SW2 = 4;
	localparam int MW  = (NW > OUT_WIDTH + 1) ? NW : OUT_WIDTH + 1;
	localparam logic [MW-1:0] NEG_LIM = MW'(1) << (OUT_WIDTH - 1);
	localparam logic [MW-1:0] POS_LIM = NEG_LIM - MW'(1);

	function automatic logic [OUT_WIDTH-1:0] sat_root(input logic neg,
			input logic [NW-1:0] mag);
		logic [MW-1:0] m;
		logic [MW-1:0] r;
		begin
			m = MW'(mag);
			if (neg)
				r = (m > NEG_LIM) ? -NEG_LIM : -m;
			else
				r = (m > POS_LIM) ? POS_LIM : m;
			sat_root = r[OUT_WIDTH-1:0];
		end
	endfunction

	logic en;

	logic              f_valid;
	logic [2*RW-1:0]   f_x;
	status_t           f_status;
	logic [W-1:0]      f_a, f_b;

	logic              s_valid;
	logic [RW-1:0]     s_root;
	logic [SW1-1:0]    s_side;
	status_t           s_status;
	logic [W-1:0]      s_a, s_b;

	logic [W+10:0]     base, rr, sum_m, sum_p, am, ap;
	logic [W-1:0]      amag;

	logic              vld_s3;
	logic [NW-1:0]     num_m_s3, num_p_s3;
	logic [W-1:0]      den_s3;
	logic [SW2-1:0]    side_s3;

	logic              d_valid;
	logic [NW-1:0]     d_qm, d_qp;
	logic [SW2-1:0]    d_side;
	status_t           d_status;

	logic              out_valid_q;
	logic [OUT_WIDTH-1:0] root_minus_q, root_plus_q;
	status_t           status_q;

	// the pipeline moves unless a finished result is still waiting
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	qrs_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.a        (coef_a),
		.b        (coef_b),
		.c        (coef_c),
		.out_valid(f_valid),
		.x        (f_x),
		.status   (f_status),
		.a_out    (f_a),
		.b_out    (f_b)
	);

	qrs_sqrt #(.RW(RW), .SW(SW1)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.x        (f_x),
		.side_in  ({f_status, f_a, f_b}),
		.out_valid(s_valid),
		.root     (s_root),
		.side_out (s_side)
	);

	assign {s_status, s_a, s_b} = s_side;

	// numerators (-b*2^8 -/+ r) * 2^7 as sign and magnitude
	always_comb begin
		base  = -({{11{s_b[W-1]}}, s_b} << B_SHIFT);
		rr    = {2'b00, s_root};
		sum_m = base - rr;
		sum_p = base + rr;
		am    = sum_m[W+10] ? -sum_m : sum_m;
		ap    = sum_p[W+10] ? -sum_p : sum_p;
		amag  = s_a[W-1] ? -s_a : s_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= s_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_m_s3 <= NW'({am[W+9:0], {N_SHIFT{1'b0}}});
			num_p_s3 <= NW'({ap[W+9:0], {N_SHIFT{1'b0}}});
			den_s3   <= amag;
			side_s3  <= {s_status, sum_m[W+10] ^ s_a[W-1], sum_p[W+10] ^ s_a[W-1]};
		end
	end

	qrs_div #(.NW(NW), .DW(W), .SW(SW2)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.num_m    (num_m_s3),
		.num_p    (num_p_s3),
		.den      (den_s3),
		.side_in  (side_s3),
		.out_valid(d_valid),
		.quo_m    (d_qm),
		.quo_p    (d_qp),
		.side_out (d_side)
	);

	assign d_status = d_side[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= d_status;
			if (d_status == STATUS_OK) begin
				root_minus_q <= sat_root(d_side[1], d_qm);
				root_plus_q  <= sat_root(d_side[0], d_qp);
			end else begin
				root_minus_q <= '0;
				root_plus_q  <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign root_minus = root_minus_q;
	assign root_plus  = root_plus_q;
	assign status     = status_q;

	`QRS_ASSERT_IMP(a_err_roots_zero, out_valid && (status != STATUS_OK),
		(root_minus == '0) && (root_plus == '0))
	`QRS_ASSERT_IMP(a_status_code, out_valid,
		(status == STATUS_OK) || (status == STATUS_NEG) || (status == STATUS_AZERO))
	`QRS_ASSERT_NXT(a_held_result, out_valid && !out_ready,
		out_valid && (status == $past(status)) && (root_plus == $past(root_plus)))

endmodule
